// ----- src/pidspd_pkg.sv -----
// ----------------------------------------------------------------------------
// pidspd_pkg
// Shared widths, codes and types for the PID speed / PWM controller.
// ----------------------------------------------------------------------------
package pidspd_pkg;

  // field and state widths
  localparam int unsigned SpeedW   = 32;
  localparam int unsigned GainW    = 16;
  localparam int unsigned SumW     = 40;
  localparam int unsigned AccW     = 48;
  localparam int unsigned DutyW    = 8;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned SelW     = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // fixed point: gains are Q4.12, duty is the integer part of a Q.16 value
  localparam int unsigned FracShift = 12;
  localparam int unsigned IntShift  = 16;

  // controller modes; the unused code behaves as full PID
  localparam logic [ModeW-1:0] MODE_P   = 2'd0;
  localparam logic [ModeW-1:0] MODE_PI  = 2'd1;
  localparam logic [ModeW-1:0] MODE_PID = 2'd2;

  // motor select codes
  localparam logic [SelW-1:0] SEL_LEFT  = 2'd0;
  localparam logic [SelW-1:0] SEL_RIGHT = 2'd1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_MODE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TARGET  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_P  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_PWM_MIN = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_PWM_MAX = 3'd6;

  // reset values of the configuration registers
  localparam logic [ModeW-1:0] MODE_RESET    = MODE_PID;
  localparam logic [DutyW-1:0] PWM_MAX_RESET = '1;

  typedef struct packed {
    logic        [ModeW-1:0]  mode;
    logic signed [SpeedW-1:0] target_speed;
    logic signed [GainW-1:0]  gain_p;
    logic signed [GainW-1:0]  gain_i;
    logic signed [GainW-1:0]  gain_d;
    logic        [DutyW-1:0]  pwm_min;
    logic        [DutyW-1:0]  pwm_max;
  } pid_cfg_t;

  typedef struct packed {
    logic signed [SumW-1:0]   error_sum;
    logic signed [AccW-1:0]   control_acc;
    logic signed [SpeedW-1:0] previous_error;
  } pid_state_t;

endpackage

// ----- src/pidspd_if.sv -----
// ----------------------------------------------------------------------------
// pidspd_if
// Valid/ready channels carrying control step words and duty result words.
// ----------------------------------------------------------------------------
interface pidspd_in_if;
  import pidspd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SpeedW-1:0] measured_speed;
  logic        [SelW-1:0]   motor_select;

  modport source (output valid, output measured_speed, output motor_select, input ready);
  modport sink   (input valid, input measured_speed, input motor_select, output ready);
endinterface

interface pidspd_out_if;
  import pidspd_pkg::*;

  logic             valid;
  logic             ready;
  logic [DutyW-1:0] pwm_duty;
  logic             accepted;

  modport source (output valid, output pwm_duty, output accepted, input ready);
  modport sink   (input valid, input pwm_duty, input accepted, output ready);
endinterface

// ----- src/pidspd_step.sv -----
// ----------------------------------------------------------------------------
// pidspd_step
// One control step: error, saturating sums, weighted terms and clamped duty.
// ----------------------------------------------------------------------------
module pidspd_step (
  input  pidspd_pkg::pid_cfg_t               cfg_i,
  input  pidspd_pkg::pid_state_t             state_i,
  input  logic [pidspd_pkg::DutyW-1:0]       duty_hold_i,
  input  logic signed [pidspd_pkg::SpeedW-1:0] measured_speed_i,
  input  logic [pidspd_pkg::SelW-1:0]        motor_select_i,
  output pidspd_pkg::pid_state_t             state_o,
  output logic [pidspd_pkg::DutyW-1:0]       duty_o,
  output logic                               accepted_o
);
  import pidspd_pkg::*;

  localparam int unsigned DeW    = SpeedW + 1;
  localparam int unsigned PropW  = GainW + SpeedW;
  localparam int unsigned IntgW  = GainW + SumW;
  localparam int unsigned DerW   = GainW + DeW;
  localparam int unsigned TotalW = IntgW + 2;
  localparam int unsigned StepW  = TotalW - FracShift;
  localparam int unsigned MagW   = AccW - IntShift;

  logic                     sel_ok;
  logic signed [SpeedW:0]   err_wide;
  logic signed [SpeedW-1:0] err;
  logic signed [DeW-1:0]    de;
  logic signed [SumW:0]     sum_wide;
  logic signed [SumW-1:0]   sum_sat;
  logic signed [SumW-1:0]   sum_new;
  logic signed [PropW-1:0]  prod_p;
  logic signed [IntgW-1:0]  prod_i;
  logic signed [DerW-1:0]   prod_d;
  logic signed [IntgW-1:0]  term_i;
  logic signed [DerW-1:0]   term_d;
  logic signed [TotalW-1:0] total;
  logic signed [StepW-1:0]  step;
  logic signed [AccW:0]     acc_wide;
  logic signed [AccW-1:0]   acc_new;
  logic        [AccW-1:0]   mag;
  logic        [MagW-1:0]   duty_wide;
  logic        [DutyW-1:0]  duty_hi;
  logic        [DutyW-1:0]  duty_new;
  logic                     use_i;
  logic                     use_d;

  assign sel_ok = (motor_select_i == SEL_LEFT) || (motor_select_i == SEL_RIGHT);
  assign use_i  = (cfg_i.mode != MODE_P);
  assign use_d  = (cfg_i.mode >= MODE_PID);

  // error, saturated to the speed range
  always_comb begin
    err_wide = {cfg_i.target_speed[SpeedW-1], cfg_i.target_speed}
             - {measured_speed_i[SpeedW-1], measured_speed_i};
    if (err_wide[SpeedW] != err_wide[SpeedW-1]) begin
      err = err_wide[SpeedW] ? {1'b1, {(SpeedW-1){1'b0}}} : {1'b0, {(SpeedW-1){1'b1}}};
    end else begin
      err = err_wide[SpeedW-1:0];
    end
  end

  // difference from the last error, kept exact
  assign de = {err[SpeedW-1], err} - {state_i.previous_error[SpeedW-1], state_i.previous_error};

  // saturating error sum
  always_comb begin
    sum_wide = {state_i.error_sum[SumW-1], state_i.error_sum}
             + {{(SumW + 1 - SpeedW){err[SpeedW-1]}}, err};
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_sat = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SumW-1:0];
    end
    sum_new = use_i ? sum_sat : state_i.error_sum;
  end

  // weighted terms, exact at Q.12
  assign prod_p = PropW'($signed(cfg_i.gain_p)) * PropW'($signed(err));
  assign prod_i = IntgW'($signed(cfg_i.gain_i)) * IntgW'($signed(sum_new));
  assign prod_d = DerW'($signed(cfg_i.gain_d)) * DerW'($signed(de));
  assign term_i = use_i ? prod_i : '0;
  assign term_d = use_d ? prod_d : '0;
  assign total  = TotalW'(prod_p) + TotalW'(term_i) + TotalW'(term_d);

  // dropping the low bits of a two's complement value rounds toward minus infinity
  assign step = total[TotalW-1:FracShift];

  // saturating control accumulator
  always_comb begin
    acc_wide = {state_i.control_acc[AccW-1], state_i.control_acc}
             + {{(AccW + 1 - StepW){step[StepW-1]}}, step};
    if (acc_wide[AccW] != acc_wide[AccW-1]) begin
      acc_new = acc_wide[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      acc_new = acc_wide[AccW-1:0];
    end
  end

  // magnitude, integer part, clamp to max then min
  always_comb begin
    mag       = acc_new[AccW-1] ? (~acc_new + AccW'(1)) : acc_new;
    duty_wide = mag[AccW-1:IntShift];
    if (duty_wide >= MagW'(cfg_i.pwm_max)) begin
      duty_hi = cfg_i.pwm_max;
    end else begin
      duty_hi = duty_wide[DutyW-1:0];
    end
    if (duty_hi <= cfg_i.pwm_min) begin
      duty_new = cfg_i.pwm_min;
    end else begin
      duty_new = duty_hi;
    end
  end

  // a rejected select leaves everything as it was
  always_comb begin
    if (sel_ok) begin
      state_o.error_sum      = sum_new;
      state_o.control_acc    = acc_new;
      state_o.previous_error = err;
      duty_o                 = duty_new;
    end else begin
      state_o = state_i;
      duty_o  = duty_hold_i;
    end
  end

  assign accepted_o = sel_ok;

endmodule

// ----- src/pid_speed_pwm_controller.sv -----
// ----------------------------------------------------------------------------
// pid_speed_pwm_controller
// Incremental P/PI/PID speed controller producing a shared PWM duty.
// ----------------------------------------------------------------------------
// The block takes one control step word per clock while the output side is
// not stalled and returns one duty word per step: the word is captured in
// an input register, then the whole step (error, error sum, three products,
// accumulator update and duty clamp) runs through combinational logic into
// the state and result registers. The rate of one word per cycle rests on
// that update of the error sum and control accumulator, which the next step
// reads. A word with an unknown motor select returns
// the held duty with accepted low and leaves the controller state alone.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while no
// step is in flight; writes to unused indexes are ignored.
module pid_speed_pwm_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pidspd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pidspd_pkg::CfgDataW-1:0]   cfg_wdata_i,
  pidspd_in_if.sink                         in_if,
  pidspd_out_if.source                      out_if
);
  import pidspd_pkg::*;

  pid_cfg_t                 cfg_q;
  pid_state_t               state_q;
  pid_state_t               state_d;
  logic [DutyW-1:0]         duty_hold_q;
  logic [DutyW-1:0]         duty_hold_d;
  logic                     s1_valid_q;
  logic signed [SpeedW-1:0] s1_meas_q;
  logic [SelW-1:0]          s1_sel_q;
  logic                     out_valid_q;
  logic                     out_acc_q;
  logic                     out_acc_d;
  logic                     out_free;
  logic                     s1_fire;
  logic                     in_fire;

  // handshake: input register feeds the result register
  assign out_free    = !out_valid_q || out_if.ready;
  assign s1_fire     = s1_valid_q && out_free;
  assign in_if.ready = !s1_valid_q || s1_fire;
  assign in_fire     = in_if.valid && in_if.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= MODE_RESET;
      cfg_q.target_speed <= '0;
      cfg_q.gain_p       <= '0;
      cfg_q.gain_i       <= '0;
      cfg_q.gain_d       <= '0;
      cfg_q.pwm_min      <= '0;
      cfg_q.pwm_max      <= PWM_MAX_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:    cfg_q.mode         <= cfg_wdata_i[ModeW-1:0];
        REG_TARGET:  cfg_q.target_speed <= cfg_wdata_i[SpeedW-1:0];
        REG_GAIN_P:  cfg_q.gain_p       <= cfg_wdata_i[GainW-1:0];
        REG_GAIN_I:  cfg_q.gain_i       <= cfg_wdata_i[GainW-1:0];
        REG_GAIN_D:  cfg_q.gain_d       <= cfg_wdata_i[GainW-1:0];
        REG_PWM_MIN: cfg_q.pwm_min      <= cfg_wdata_i[DutyW-1:0];
        REG_PWM_MAX: cfg_q.pwm_max      <= cfg_wdata_i[DutyW-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_meas_q <= in_if.measured_speed;
      s1_sel_q  <= in_if.motor_select;
    end
  end

  // single-pass step logic
  pidspd_step u_step (
    .cfg_i            (cfg_q),
    .state_i          (state_q),
    .duty_hold_i      (duty_hold_q),
    .measured_speed_i (s1_meas_q),
    .motor_select_i   (s1_sel_q),
    .state_o          (state_d),
    .duty_o           (duty_hold_d),
    .accepted_o       (out_acc_d)
  );

  // controller state and held duty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      duty_hold_q <= '0;
    end else if (s1_fire) begin
      state_q     <= state_d;
      duty_hold_q <= duty_hold_d;
    end
  end

  // result register; the duty word is the held duty, which only moves with it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_acc_q <= out_acc_d;
    end
  end

  assign out_if.valid    = out_valid_q;
  assign out_if.pwm_duty = duty_hold_q;
  assign out_if.accepted = out_acc_q;

`ifndef SYNTHESIS
  // a rejected select leaves the controller state untouched
  a_reject_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !(s1_sel_q == SEL_LEFT || s1_sel_q == SEL_RIGHT)
    |=> $stable(state_q) && $stable(duty_hold_q))
    else $error("state changed on rejected select");

  // proportional mode never moves the error sum
  a_p_mode_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (cfg_q.mode == MODE_P) |=> $stable(state_q.error_sum))
    else $error("error sum moved in proportional mode");

  // every processed step produces a result word
  a_step_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("processed step lost its result");

  // a stalled step waits in the input register
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_fire |=> s1_valid_q && $stable(s1_meas_q) && $stable(s1_sel_q))
    else $error("stalled step dropped from input register");

  // state only moves when a step is processed
  a_state_only_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(state_q))
    else $error("state moved without a step");
`endif

endmodule
